FILE: rtl/core/gcvg_pkg.sv
package gcvg_pkg;

  localparam int EDGE_ID_BITS = 20;
  localparam int FRAC_BITS    = 16;
  localparam int SLOT_COUNT   = 3;

  // field widths fixed by the item layout
  localparam int ID_FIELD_W = 20;
  localparam int VAL_W      = 32;

  // id bits that take part in the slot compare
  localparam int KEY_W  = (EDGE_ID_BITS < ID_FIELD_W) ? EDGE_ID_BITS : ID_FIELD_W;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int PTR_W  = $clog2(SLOT_COUNT + 1);

  // scaled magnitude is clamped to 2^CAP_EXP
  localparam int CAP_EXP = 34;
  localparam int QUO_W   = CAP_EXP + 1;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int NUM_W   = PROD_W + FRAC_BITS;
  localparam int S_W     = PROD_W;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int SUM_W   = QUO_W + 2;
  localparam int TERMS   = 4;
  localparam int TERM_W  = $clog2(TERMS);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [ID_FIELD_W-1:0] edge_id;
    logic [VAL_W-1:0]      offset_x;
    logic [VAL_W-1:0]      offset_y;
    logic [VAL_W-1:0]      inner_dvx_dx;
    logic [VAL_W-1:0]      inner_dvx_dy;
    logic [VAL_W-1:0]      inner_dvy_dx;
    logic [VAL_W-1:0]      inner_dvy_dy;
    logic [VAL_W-1:0]      inner_vel_x;
    logic [VAL_W-1:0]      inner_vel_y;
    logic [VAL_W-1:0]      ghost_vel_x;
    logic [VAL_W-1:0]      ghost_vel_y;
  } req_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] ghost_dvx_dx;
    logic [VAL_W-1:0] ghost_dvx_dy;
    logic [VAL_W-1:0] ghost_dvy_dx;
    logic [VAL_W-1:0] ghost_dvy_dy;
    logic             edge_missing;
  } res_item_t;

endpackage

FILE: rtl/core/gcvg_req_if.sv
interface gcvg_req_if import gcvg_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/gcvg_res_if.sv
interface gcvg_res_if import gcvg_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ghost_cell_velocity_gradient_top.sv
// Channel   Dir  Interface     Item
// request   in   gcvg_req_if   load edge slot / compute ghost gradient
// result    out  gcvg_res_if   four ghost gradient terms and edge_missing
//
// A load item leaves request ready; the block stays idle.
// A compute item raises result.valid after the squared length, then per term a multiply,
// an overflow check and 35 quotient bits from the shared divider. An overflowing term
// skips the divide, a zero offset ends at the first multiply, no match goes to output.
// Request is not ready from a compute item's acceptance until its result is taken.
// rst is synchronous, active high; it empties the slots and stops any work.
module ghost_cell_velocity_gradient_top import gcvg_pkg::*; (
  input logic        clk,
  input logic        rst,
  gcvg_req_if.sink   request,
  gcvg_res_if.source result
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SQ_X     = 9'b000000010,
    ST_SQ_Y     = 9'b000000100,
    ST_SUM_S    = 9'b000001000,
    ST_TERM_MUL = 9'b000010000,
    ST_TERM_CHK = 9'b000100000,
    ST_DIV      = 9'b001000000,
    ST_TERM_FIN = 9'b010000000,
    ST_OUT      = 9'b100000000
  } state_t;

  localparam logic [QUO_W-1:0] MAG_CAP = QUO_W'(1) << CAP_EXP;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

  function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] v);
    abs_val = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
  endfunction

  state_t state;

  // edge slots
  logic [KEY_W-1:0]      slot_id [SLOT_COUNT];
  logic [VAL_W-1:0]      slot_ox [SLOT_COUNT];
  logic [VAL_W-1:0]      slot_oy [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [PTR_W-1:0]      load_pointer;

  // working registers
  logic [VAL_W-1:0]  ax_mag, ay_mag, dvx_mag, dvy_mag;
  logic              ax_neg, ay_neg, dvx_neg, dvy_neg;
  logic [VAL_W-1:0]  grad [TERMS];
  logic [VAL_W-1:0]  inner_vx, inner_vy, ghost_vx, ghost_vy;
  logic [PROD_W-1:0] prod;
  logic [S_W-1:0]    s;
  logic [S_W-1:0]    rem;
  logic [QUO_W-1:0]  nq;
  logic              cap_hit;
  logic [CNT_W-1:0]  cnt;
  logic [TERM_W-1:0] term;
  logic [VAL_W-1:0]  gterm [TERMS];
  logic              missing;

  // slot lookup
  logic [KEY_W-1:0]      key;
  logic [SLOT_COUNT-1:0] match;
  logic                  hit_any;
  logic [SLOT_W-1:0]     hit_idx;

  assign key = request.data.edge_id[KEY_W-1:0];

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      match[k] = slot_valid[k] && (slot_id[k] == key);
    end
    // lowest matching slot wins
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(k);
      end
    end
  end

  // velocity differences
  logic signed [VAL_W:0] dvx, dvy;
  assign dvx = $signed({ghost_vx[VAL_W-1], ghost_vx}) - $signed({inner_vx[VAL_W-1], inner_vx});
  assign dvy = $signed({ghost_vy[VAL_W-1], ghost_vy}) - $signed({inner_vy[VAL_W-1], inner_vy});

  // shared multiplier
  logic [VAL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_out;

  always_comb begin
    case (state)
      ST_SQ_X: begin
        mul_a = ax_mag;
        mul_b = ax_mag;
      end
      ST_SQ_Y: begin
        mul_a = ay_mag;
        mul_b = ay_mag;
      end
      default: begin
        mul_a = term[0] ? ay_mag : ax_mag;
        mul_b = term[1] ? dvy_mag : dvx_mag;
      end
    endcase
  end

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  // divider step and overflow check
  logic [NUM_W-1:0]   num;
  logic [S_W-1:0]     num_hi;
  logic [S_W:0]       trial;
  logic               qbit;
  assign num    = {prod, {FRAC_BITS{1'b0}}};
  assign num_hi = S_W'(num[NUM_W-1:QUO_W]);
  assign trial  = {rem, nq[QUO_W-1]};
  assign qbit   = (trial >= {1'b0, s});

  // signed term, inner gradient subtracted, saturated
  logic [QUO_W-1:0]        mag;
  logic                    term_neg;
  logic signed [SUM_W-1:0] val_s, grad_s, diff;
  logic [VAL_W-1:0]        sat;

  always_comb begin
    mag      = (cap_hit || (nq > MAG_CAP)) ? MAG_CAP : nq;
    term_neg = (term[0] ? ay_neg : ax_neg) ^ (term[1] ? dvy_neg : dvx_neg);
    val_s    = term_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    grad_s   = $signed({{(SUM_W - VAL_W){grad[term][VAL_W-1]}}, grad[term]});
    diff     = val_s - grad_s;
    if (diff > SAT_HI) begin
      sat = SAT_HI[VAL_W-1:0];
    end else if (diff < SAT_LO) begin
      sat = SAT_LO[VAL_W-1:0];
    end else begin
      sat = diff[VAL_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_valid   <= '0;
      load_pointer <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (request.valid) begin
            if (request.data.command == CMD_LOAD) begin
              // drop loads once all slots are full
              if (load_pointer < PTR_W'(SLOT_COUNT)) begin
                slot_valid[load_pointer[SLOT_W-1:0]] <= 1'b1;
                load_pointer <= load_pointer + PTR_W'(1);
              end
            end else begin
              slot_valid   <= '0;
              load_pointer <= '0;
              state        <= hit_any ? ST_SQ_X : ST_OUT;
            end
          end
        end
        ST_SQ_X:     state <= ST_SQ_Y;
        ST_SQ_Y:     state <= ST_SUM_S;
        ST_SUM_S:    state <= ST_TERM_MUL;
        ST_TERM_MUL: state <= (s == '0) ? ST_OUT : ST_TERM_CHK;
        ST_TERM_CHK: state <= (num_hi >= s) ? ST_TERM_FIN : ST_DIV;
        ST_DIV: begin
          if (cnt == CNT_W'(1)) begin
            state <= ST_TERM_FIN;
          end
        end
        ST_TERM_FIN: state <= (term == TERM_W'(TERMS - 1)) ? ST_OUT : ST_TERM_MUL;
        ST_OUT: begin
          if (result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (request.valid) begin
          if (request.data.command == CMD_LOAD) begin
            if (load_pointer < PTR_W'(SLOT_COUNT)) begin
              slot_id[load_pointer[SLOT_W-1:0]] <= key;
              slot_ox[load_pointer[SLOT_W-1:0]] <= request.data.offset_x;
              slot_oy[load_pointer[SLOT_W-1:0]] <= request.data.offset_y;
            end
          end else begin
            ax_mag   <= abs_val(slot_ox[hit_idx]);
            ay_mag   <= abs_val(slot_oy[hit_idx]);
            ax_neg   <= slot_ox[hit_idx][VAL_W-1];
            ay_neg   <= slot_oy[hit_idx][VAL_W-1];
            grad[0]  <= request.data.inner_dvx_dx;
            grad[1]  <= request.data.inner_dvx_dy;
            grad[2]  <= request.data.inner_dvy_dx;
            grad[3]  <= request.data.inner_dvy_dy;
            inner_vx <= request.data.inner_vel_x;
            inner_vy <= request.data.inner_vel_y;
            ghost_vx <= request.data.ghost_vel_x;
            ghost_vy <= request.data.ghost_vel_y;
            term     <= '0;
            missing  <= !hit_any;
            for (int t = 0; t < TERMS; t++) begin
              gterm[t] <= '0;
            end
          end
        end
      end
      ST_SQ_X: begin
        prod    <= mul_out;
        dvx_neg <= dvx[VAL_W];
        dvy_neg <= dvy[VAL_W];
        dvx_mag <= dvx[VAL_W] ? VAL_W'(-dvx) : VAL_W'(dvx);
        dvy_mag <= dvy[VAL_W] ? VAL_W'(-dvy) : VAL_W'(dvy);
      end
      ST_SQ_Y: begin
        prod <= mul_out;
        s    <= prod;
      end
      ST_SUM_S: begin
        s <= s + prod;
      end
      ST_TERM_MUL: begin
        prod <= mul_out;
        if (s == '0) begin
          missing <= 1'b1;
        end
      end
      ST_TERM_CHK: begin
        // quotient at or above 2^QUO_W: clamp without dividing
        cap_hit <= (num_hi >= s);
        rem     <= num_hi;
        nq      <= num[QUO_W-1:0];
        cnt     <= CNT_W'(QUO_W);
      end
      ST_DIV: begin
        // shift numerator bits out of nq, quotient bits in
        rem <= qbit ? S_W'(trial - {1'b0, s}) : S_W'(trial);
        nq  <= {nq[QUO_W-2:0], qbit};
        cnt <= cnt - CNT_W'(1);
      end
      ST_TERM_FIN: begin
        gterm[term] <= sat;
        term        <= term + TERM_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign request.ready              = (state == ST_IDLE);
  assign result.valid               = (state == ST_OUT);
  assign result.data.ghost_dvx_dx   = gterm[0];
  assign result.data.ghost_dvx_dy   = gterm[1];
  assign result.data.ghost_dvy_dx   = gterm[2];
  assign result.data.ghost_dvy_dy   = gterm[3];
  assign result.data.edge_missing   = missing;

endmodule

FILE: rtl/core/gcvg_checker.sv
module gcvg_checker import gcvg_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      req_command,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_data
);

  // a waiting result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // no new item while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request ready while result pending");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.edge_missing |->
      res_data.ghost_dvx_dx == '0 && res_data.ghost_dvx_dy == '0 &&
      res_data.ghost_dvy_dx == '0 && res_data.ghost_dvy_dy == '0)
    else $error("missing edge with nonzero gradient");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_COMPUTE |=> !req_ready)
    else $error("ready right after compute item");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_LOAD |=> req_ready && !res_valid)
    else $error("load item produced a result or stalled");

endmodule

bind ghost_cell_velocity_gradient_top gcvg_checker u_gcvg_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.data.command),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_data    (result.data)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gcvg_pkg::*;

  localparam int ITEMS       = 1700;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_LEN    = 600;
  localparam int TAIL_CYCLES = 200;
  localparam logic [VAL_W-1:0] ONE     = 32'h0001_0000;
  localparam logic [VAL_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] MAX_NEG = 32'h8000_0000;

  logic clk;
  logic rst;

  gcvg_req_if request_ch ();
  gcvg_res_if result_ch ();

  ghost_cell_velocity_gradient_top dut (
    .clk(clk),
    .rst(rst),
    .request(request_ch),
    .result(result_ch)
  );

  // edge slots as the block should hold them
  logic [KEY_W-1:0] slot_id    [SLOT_COUNT];
  logic [VAL_W-1:0] slot_off_x [SLOT_COUNT];
  logic [VAL_W-1:0] slot_off_y [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_used = '0;
  int load_ptr = 0;

  req_item_t requests_pending[$];
  res_item_t grads_due[$];

  int total_items    = 0;
  int accepted_items = 0;
  int hold_at        = 0;
  int hold_cycles    = 0;
  bit hold_done      = 1'b0;
  bit req_taken      = 1'b0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int loads_stored   = 0;
  int loads_dropped  = 0;
  int grads_formed   = 0;
  int edges_missing  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one ghost gradient term: (r_axis / S) * dv - inner, saturated to 32 bits
  function automatic logic [VAL_W-1:0] grad_term(longint axis, longint dv, longint inner,
                                                 logic [S_W-1:0] len_sq);
    logic [63:0] a_mag;
    logic [63:0] b_mag;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    longint mag;
    longint diff;
    a_mag = (axis < 0) ? -axis : axis;
    b_mag = (dv < 0) ? -dv : dv;
    num = NUM_W'(a_mag * b_mag) << FRAC_BITS;
    quo = num / NUM_W'(len_sq);
    mag = (quo > (NUM_W'(1) << CAP_EXP)) ? (longint'(1) << CAP_EXP)
                                         : longint'(quo[CAP_EXP:0]);
    if ((axis < 0) != (dv < 0))
      mag = -mag;
    diff = mag - inner;
    if (diff > longint'(32'sh7FFF_FFFF))
      diff = longint'(32'sh7FFF_FFFF);
    if (diff < -longint'(64'h8000_0000))
      diff = -longint'(64'h8000_0000);
    return diff[VAL_W-1:0];
  endfunction

  // advance the slot state by one item; return 1 when the item yields a gradient
  function automatic bit step_ghost_gradient(input req_item_t it, output res_item_t r);
    int hit;
    int k;
    longint rx;
    longint ry;
    longint dvx;
    longint dvy;
    logic [S_W-1:0] len_sq;
    hit = -1;
    r = '0;
    if (it.command == CMD_LOAD) begin
      if (load_ptr < SLOT_COUNT) begin
        slot_id[load_ptr]    = it.edge_id[KEY_W-1:0];
        slot_off_x[load_ptr] = it.offset_x;
        slot_off_y[load_ptr] = it.offset_y;
        slot_used[load_ptr]  = 1'b1;
        load_ptr++;
        loads_stored++;
      end else begin
        loads_dropped++;
      end
      return 1'b0;
    end
    // lowest matching slot wins
    for (k = SLOT_COUNT - 1; k >= 0; k--)
      if (slot_used[k] && slot_id[k] == it.edge_id[KEY_W-1:0])
        hit = k;
    r.edge_missing = 1'b1;
    if (hit >= 0) begin
      rx = $signed(slot_off_x[hit]);
      ry = $signed(slot_off_y[hit]);
      len_sq = S_W'(rx * rx) + S_W'(ry * ry);
      if (len_sq != 0) begin
        dvx = longint'($signed(it.ghost_vel_x)) - longint'($signed(it.inner_vel_x));
        dvy = longint'($signed(it.ghost_vel_y)) - longint'($signed(it.inner_vel_y));
        r.ghost_dvx_dx = grad_term(rx, dvx, $signed(it.inner_dvx_dx), len_sq);
        r.ghost_dvx_dy = grad_term(ry, dvx, $signed(it.inner_dvx_dy), len_sq);
        r.ghost_dvy_dx = grad_term(rx, dvy, $signed(it.inner_dvy_dx), len_sq);
        r.ghost_dvy_dy = grad_term(ry, dvy, $signed(it.inner_dvy_dy), len_sq);
        r.edge_missing = 1'b0;
      end
    end
    if (r.edge_missing)
      edges_missing++;
    else
      grads_formed++;
    slot_used = '0;
    load_ptr = 0;
    return 1'b1;
  endfunction

  function automatic req_item_t noise_item();
    req_item_t it;
    it.command      = 1'($urandom);
    it.edge_id      = ID_FIELD_W'($urandom);
    it.offset_x     = $urandom;
    it.offset_y     = $urandom;
    it.inner_dvx_dx = $urandom;
    it.inner_dvx_dy = $urandom;
    it.inner_dvy_dx = $urandom;
    it.inner_dvy_dy = $urandom;
    it.inner_vel_x  = $urandom;
    it.inner_vel_y  = $urandom;
    it.ghost_vel_x  = $urandom;
    it.ghost_vel_y  = $urandom;
    return it;
  endfunction

  function automatic req_item_t load_item(logic [ID_FIELD_W-1:0] id, logic [VAL_W-1:0] ox,
                                          logic [VAL_W-1:0] oy);
    req_item_t it;
    it = noise_item();
    it.command  = CMD_LOAD;
    it.edge_id  = id;
    it.offset_x = ox;
    it.offset_y = oy;
    return it;
  endfunction

  function automatic req_item_t compute_item(logic [ID_FIELD_W-1:0] id,
      logic [VAL_W-1:0] gxx, logic [VAL_W-1:0] gxy, logic [VAL_W-1:0] gyx,
      logic [VAL_W-1:0] gyy, logic [VAL_W-1:0] ivx, logic [VAL_W-1:0] ivy,
      logic [VAL_W-1:0] gvx, logic [VAL_W-1:0] gvy);
    req_item_t it;
    it = noise_item();
    it.command      = CMD_COMPUTE;
    it.edge_id      = id;
    it.inner_dvx_dx = gxx;
    it.inner_dvx_dy = gxy;
    it.inner_dvy_dx = gyx;
    it.inner_dvy_dy = gyy;
    it.inner_vel_x  = ivx;
    it.inner_vel_y  = ivy;
    it.ghost_vel_x  = gvx;
    it.ghost_vel_y  = gvy;
    return it;
  endfunction

  // mostly moderate values so results do not all saturate
  function automatic logic [VAL_W-1:0] any_val();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 2**21) - 2**20;
      4, 5:       return $urandom_range(0, 2**27) - 2**26;
      6, 7:       return $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0:       return MAX_POS;
          1:       return MAX_NEG;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      default:    return $urandom_range(0, 2**13) - 2**12;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] any_offset();
    logic [VAL_W-1:0] mag;
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return $urandom;
      default: begin
        mag = $urandom_range(1, 2**20) >> $urandom_range(0, 14);
        return $urandom_range(0, 1) ? -mag : mag;
      end
    endcase
  endfunction

  // small ids collide on purpose now and then
  function automatic logic [ID_FIELD_W-1:0] any_id();
    if ($urandom_range(0, 3) == 0)
      return ID_FIELD_W'($urandom_range(0, 7));
    return ID_FIELD_W'($urandom);
  endfunction

  function automatic req_item_t random_compute(logic [ID_FIELD_W-1:0] id);
    return compute_item(id, any_val(), any_val(), any_val(), any_val(),
                        any_val(), any_val(), any_val(), any_val());
  endfunction

  function automatic int send_idle_pct();
    case (accepted_items * 3 / ((total_items > 0) ? total_items : 1))
      0:       return 10;
      1:       return 71;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (accepted_items * 3 / ((total_items > 0) ? total_items : 1))
      0:       return 71;
      1:       return 10;
      default: return 0;
    endcase
  endfunction

  task automatic field_check(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch on %s in result %0d: expected %h, got %h",
                 name, results_seen, want, got);
      mismatches++;
    end
  endtask

  // driver: hold an item until taken, then advance
  always @(negedge clk) begin
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else if (!request_ch.valid || req_taken) begin
      if (requests_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        request_ch.valid <= 1'b1;
        request_ch.data  <= requests_pending.pop_front();
      end else begin
        request_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
  end

  // long receiver hold-off late in the run, so the request side backs up
  always @(posedge clk) begin
    if (!rst && !hold_done && total_items > 0 && accepted_items >= hold_at) begin
      hold_cycles <= HOLD_LEN;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor: predict on every accepted item, check every taken result
  always @(posedge clk) begin
    res_item_t want;
    res_item_t got;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= request_ch.valid && request_ch.ready;
      if (request_ch.valid && request_ch.ready) begin
        accepted_items <= accepted_items + 1;
        if (step_ghost_gradient(request_ch.data, want))
          grads_due.push_back(want);
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (grads_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: %p", results_seen, got);
          mismatches++;
        end else begin
          want = grads_due.pop_front();
          field_check("ghost_dvx_dx", want.ghost_dvx_dx, got.ghost_dvx_dx);
          field_check("ghost_dvx_dy", want.ghost_dvx_dy, got.ghost_dvx_dy);
          field_check("ghost_dvy_dx", want.ghost_dvy_dx, got.ghost_dvy_dx);
          field_check("ghost_dvy_dy", want.ghost_dvy_dy, got.ghost_dvy_dy);
          field_check("edge_missing", 32'(want.edge_missing), 32'(got.edge_missing));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d items queued and %0d results outstanding",
               requests_pending.size(), grads_due.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    logic [ID_FIELD_W-1:0] ids[5];
    int n;
    int k;
    int pick;
    rst = 1'b1;
    request_ch.valid = 1'b0;
    request_ch.data  = '0;
    result_ch.ready  = 1'b0;

    // nothing loaded yet: edge is missing
    requests_pending.push_back(compute_item(20'd5, ONE, ONE, ONE, ONE, '0, '0, ONE, ONE));
    // unit offsets, match on the all-ones id in the middle slot
    requests_pending.push_back(load_item(20'd0, ONE, '0));
    requests_pending.push_back(load_item(20'hFFFFF, '0, ONE));
    requests_pending.push_back(load_item(20'd7, 32'h0000_8000, 32'hFFFF_8000));
    requests_pending.push_back(compute_item(20'hFFFFF, 32'h0000_4000, 32'hFFFF_C000,
                                            32'h0001_8000, '0, ONE, '0, 2 * ONE, -2 * ONE));
    // match in the last slot
    requests_pending.push_back(load_item(20'd100, ONE, ONE));
    requests_pending.push_back(load_item(20'd101, -ONE, ONE));
    requests_pending.push_back(load_item(20'd102, 32'h0003_0000, 32'h0004_0000));
    requests_pending.push_back(compute_item(20'd102, ONE, -ONE, '0, 32'h0000_0001,
                                            -ONE, ONE, 3 * ONE, -5 * ONE));
    // same id in two slots: the lower slot wins
    requests_pending.push_back(load_item(20'd9, 2 * ONE, '0));
    requests_pending.push_back(load_item(20'd9, ONE, ONE));
    requests_pending.push_back(compute_item(20'd9, '0, '0, '0, '0, '0, '0, ONE, ONE));
    // fourth load is dropped, so its id cannot match
    requests_pending.push_back(load_item(20'd1, ONE, '0));
    requests_pending.push_back(load_item(20'd2, ONE, '0));
    requests_pending.push_back(load_item(20'd3, ONE, '0));
    requests_pending.push_back(load_item(20'd4, ONE, '0));
    requests_pending.push_back(compute_item(20'd4, ONE, ONE, ONE, ONE, '0, '0, ONE, ONE));
    // zero offset
    requests_pending.push_back(load_item(20'd11, '0, '0));
    requests_pending.push_back(compute_item(20'd11, ONE, ONE, ONE, ONE, '0, '0, ONE, ONE));
    // largest offsets and velocity differences
    requests_pending.push_back(load_item(20'd12, MAX_NEG, MAX_NEG));
    requests_pending.push_back(compute_item(20'd12, MAX_POS, MAX_NEG, '0, '1,
                                            MAX_NEG, MAX_POS, MAX_POS, MAX_NEG));
    // tiny offset: large magnitude, output saturates both ways
    requests_pending.push_back(load_item(20'd13, 32'd1, '0));
    requests_pending.push_back(compute_item(20'd13, MAX_NEG, '0, MAX_POS, '0,
                                            '0, ONE, ONE, '0));
    // slots were released by the last compute
    requests_pending.push_back(compute_item(20'd13, ONE, ONE, ONE, ONE, '0, '0, ONE, ONE));

    while (requests_pending.size() < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        n = ($urandom_range(0, 9) < 7) ? SLOT_COUNT : $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
          ids[k] = any_id();
          requests_pending.push_back(load_item(ids[k], any_offset(), any_offset()));
        end
        requests_pending.push_back(random_compute(($urandom_range(0, 99) < 85) ?
                                                  ids[$urandom_range(0, n - 1)] : any_id()));
      end else if (pick < 92) begin
        requests_pending.push_back(random_compute(any_id()));
      end else begin
        requests_pending.push_back(load_item(any_id(), any_offset(), any_offset()));
      end
    end
    total_items = requests_pending.size();
    hold_at = total_items * 5 / 6;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_pending.size() != 0 || request_ch.valid || grads_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d slot loads (%0d dropped on full slots) in %0d items",
             loads_stored, loads_dropped, total_items);
    $display("checked %0d results: %0d ghost gradients, %0d with no usable edge",
             results_seen, grads_formed, edges_missing);
    if (mismatches == 0 && grads_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
